/* rtl/ljfs_pkg.sv */
// Shared constants, field widths and controller/datapath interface types
// for the longest-job-first scheduler. No dependencies.
package ljfs_pkg;

    localparam int MAX_JOBS_DEF = 32;
    localparam int ID_W         = 8;
    localparam int BURST_W      = 10;
    localparam int TIME_W       = 15;
    localparam int BURST_MAX    = 1023;
    localparam int SAT15        = 32767;

    typedef struct packed {
        logic load;
        logic pop;
        logic div_init;
        logic div_step;
        logic emit;
        logic clear;
    } ljfs_cmd_t;

    typedef struct packed {
        logic last_pop;
        logic out_free;
    } ljfs_status_t;

    function automatic logic [TIME_W-1:0] sat15(input logic [31:0] v);
        return (v > 32'(SAT15)) ? TIME_W'(SAT15) : v[TIME_W-1:0];
    endfunction

endpackage

/* rtl/ljfs_ctrl.sv */
// Sequencing FSM for the longest-job-first scheduler: load, drain,
// average divide and final result. Depends on ljfs_pkg.
module ljfs_ctrl #(
    parameter int MAX_JOBS = ljfs_pkg::MAX_JOBS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   batch_end,
    output logic                   in_stall,
    input  ljfs_pkg::ljfs_status_t status,
    output ljfs_pkg::ljfs_cmd_t    cmd
);
    import ljfs_pkg::*;

    localparam int TOT_W  = $clog2(MAX_JOBS * MAX_JOBS * BURST_MAX + 1);
    localparam int STEP_W = $clog2(TOT_W + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DRAIN,
        S_DIV,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_LOAD);
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (batch_end)
                        state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.pop = 1'b1;
                    if (status.last_pop)
                    begin
                        state_next = S_DIV;
                        step_next  = '0;
                    end
                end
            end
            S_DIV:
            begin
                if (step_reg == '0)
                    cmd.div_init = 1'b1;
                else
                    cmd.div_step = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TOT_W))
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* rtl/ljfs_datapath.sv */
// Datapath: sorted insertion store, drain accumulators, two restoring
// dividers for the averages, and the output register. Depends on ljfs_pkg.
module ljfs_datapath #(
    parameter int MAX_JOBS = ljfs_pkg::MAX_JOBS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ljfs_pkg::ID_W-1:0]     job_id,
    input  logic [ljfs_pkg::BURST_W-1:0]  burst,
    input  ljfs_pkg::ljfs_cmd_t           cmd,
    output ljfs_pkg::ljfs_status_t        status,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [ljfs_pkg::ID_W-1:0]     job_tag,
    output logic [ljfs_pkg::BURST_W-1:0]  run_length,
    output logic [ljfs_pkg::TIME_W-1:0]   wait_time,
    output logic [ljfs_pkg::TIME_W-1:0]   turnaround,
    output logic [ljfs_pkg::TIME_W-1:0]   avg_wait,
    output logic [ljfs_pkg::TIME_W-1:0]   avg_turnaround,
    output logic                          final_result,
    output logic                          overflow
);
    import ljfs_pkg::*;

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CLK_W = $clog2(MAX_JOBS * BURST_MAX + 1);
    localparam int TOT_W = $clog2(MAX_JOBS * MAX_JOBS * BURST_MAX + 1);

    logic [BURST_W-1:0] burst_reg [MAX_JOBS];
    logic [BURST_W-1:0] burst_next [MAX_JOBS];
    logic [ID_W-1:0]    tag_reg [MAX_JOBS];
    logic [ID_W-1:0]    tag_next [MAX_JOBS];
    logic [MAX_JOBS-1:0] ge, occ;

    logic [CNT_W-1:0]   count_reg, pop_cnt_reg;
    logic               dropped_reg;
    logic [CLK_W-1:0]   clock_reg;
    logic [TOT_W-1:0]   tot_wait_reg, tot_turn_reg;
    logic               out_valid_reg;

    logic [ID_W-1:0]    hold_tag_reg;
    logic [BURST_W-1:0] hold_burst_reg;
    logic [TIME_W-1:0]  hold_wait_reg, hold_turn_reg;
    logic               hold_overflow_reg;

    logic [TOT_W-1:0]   dq_wait_reg, dq_turn_reg;
    logic [CNT_W-1:0]   rem_wait_reg, rem_turn_reg;

    logic [ID_W-1:0]    job_tag_reg;
    logic [BURST_W-1:0] run_length_reg;
    logic [TIME_W-1:0]  wait_time_reg, turnaround_reg, avg_wait_reg, avg_turn_reg;
    logic               final_reg, overflow_reg;

    logic               full, insert;
    logic [CLK_W-1:0]   end_time;
    logic [CNT_W:0]     w_shift, t_shift, w_diff, t_diff, divisor;
    logic               w_ge, t_ge;

    assign full     = (count_reg == CNT_W'(MAX_JOBS));
    assign insert   = cmd.load && !full;
    assign end_time = clock_reg + CLK_W'(burst_reg[0]);

    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.last_pop = ((pop_cnt_reg + CNT_W'(1)) == count_reg);

    // Sorted insertion: entries shorter than the new job move down one slot; a pop moves every entry up one slot.
    always_comb
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            ge[i]         = (burst_reg[i] >= burst);
            occ[i]        = (CNT_W'(i) < count_reg);
            burst_next[i] = burst_reg[i];
            tag_next[i]   = tag_reg[i];
        end
        if (insert)
        begin
            if (!(occ[0] && ge[0]))
            begin
                burst_next[0] = burst;
                tag_next[0]   = job_id;
            end
            for (int i = 1; i < MAX_JOBS; i++)
            begin
                if (!(occ[i] && ge[i]))
                begin
                    if (ge[i-1])
                    begin
                        burst_next[i] = burst;
                        tag_next[i]   = job_id;
                    end
                    else
                    begin
                        burst_next[i] = burst_reg[i-1];
                        tag_next[i]   = tag_reg[i-1];
                    end
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < MAX_JOBS - 1; i++)
            begin
                burst_next[i] = burst_reg[i+1];
                tag_next[i]   = tag_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_JOBS; i++)
        begin
            burst_reg[i] <= burst_next[i];
            tag_reg[i]   <= tag_next[i];
        end
    end

    // Restoring divide step, one quotient bit per cycle for each average.
    assign divisor = {1'b0, count_reg};
    assign w_shift = {rem_wait_reg, dq_wait_reg[TOT_W-1]};
    assign t_shift = {rem_turn_reg, dq_turn_reg[TOT_W-1]};
    assign w_ge    = (w_shift >= divisor);
    assign t_ge    = (t_shift >= divisor);
    assign w_diff  = w_shift - divisor;
    assign t_diff  = t_shift - divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pop_cnt_reg   <= '0;
            dropped_reg   <= 1'b0;
            clock_reg     <= '0;
            tot_wait_reg  <= '0;
            tot_turn_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg    <= '0;
                pop_cnt_reg  <= '0;
                dropped_reg  <= 1'b0;
                clock_reg    <= '0;
                tot_wait_reg <= '0;
                tot_turn_reg <= '0;
            end
            else
            begin
                if (insert)
                    count_reg <= count_reg + CNT_W'(1);
                if (cmd.load && full)
                    dropped_reg <= 1'b1;
                if (cmd.pop)
                begin
                    pop_cnt_reg  <= pop_cnt_reg + CNT_W'(1);
                    clock_reg    <= end_time;
                    tot_wait_reg <= tot_wait_reg + TOT_W'(clock_reg);
                    tot_turn_reg <= tot_turn_reg + TOT_W'(end_time);
                end
            end

            if ((cmd.pop && !status.last_pop) || cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pop && !status.last_pop)
        begin
            job_tag_reg    <= tag_reg[0];
            run_length_reg <= burst_reg[0];
            wait_time_reg  <= sat15(32'(clock_reg));
            turnaround_reg <= sat15(32'(end_time));
            avg_wait_reg   <= '0;
            avg_turn_reg   <= '0;
            final_reg      <= 1'b0;
            overflow_reg   <= dropped_reg;
        end
        else if (cmd.emit)
        begin
            job_tag_reg    <= hold_tag_reg;
            run_length_reg <= hold_burst_reg;
            wait_time_reg  <= hold_wait_reg;
            turnaround_reg <= hold_turn_reg;
            avg_wait_reg   <= sat15(32'(dq_wait_reg));
            avg_turn_reg   <= sat15(32'(dq_turn_reg));
            final_reg      <= 1'b1;
            overflow_reg   <= hold_overflow_reg;
        end

        if (cmd.pop && status.last_pop)
        begin
            hold_tag_reg      <= tag_reg[0];
            hold_burst_reg    <= burst_reg[0];
            hold_wait_reg     <= sat15(32'(clock_reg));
            hold_turn_reg     <= sat15(32'(end_time));
            hold_overflow_reg <= dropped_reg;
        end

        if (cmd.div_init)
        begin
            dq_wait_reg  <= tot_wait_reg;
            dq_turn_reg  <= tot_turn_reg;
            rem_wait_reg <= '0;
            rem_turn_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_wait_reg  <= {dq_wait_reg[TOT_W-2:0], w_ge};
            dq_turn_reg  <= {dq_turn_reg[TOT_W-2:0], t_ge};
            rem_wait_reg <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            rem_turn_reg <= t_ge ? t_diff[CNT_W-1:0] : t_shift[CNT_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign job_tag        = job_tag_reg;
    assign run_length     = run_length_reg;
    assign wait_time      = wait_time_reg;
    assign turnaround     = turnaround_reg;
    assign avg_wait       = avg_wait_reg;
    assign avg_turnaround = avg_turn_reg;
    assign final_result   = final_reg;
    assign overflow       = overflow_reg;

endmodule

/* rtl/longest_job_first_schedule.sv */
// Top level of the longest-job-first batch scheduler.
// Instantiates ljfs_ctrl and ljfs_datapath; depends on ljfs_pkg.
//
// Jobs are taken one transaction per cycle and inserted into a store kept
// sorted by burst, longest first, ties in load order; jobs beyond MAX_JOBS
// are dropped and flagged. The transaction with batch_end closes the batch,
// after which input stalls until the final result is in the output register.
// Results leave one per cycle from the head of the store. Before the final
// result the two averages are formed by restoring dividers at one bit per
// cycle: the dividers are loaded, divide over TOT_W bits, where TOT_W is the
// width of the turnaround total, and then the final result is issued.
// Output stalls stretch the drain and the final issue.
module longest_job_first_schedule #(
    parameter int MAX_JOBS = ljfs_pkg::MAX_JOBS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ljfs_pkg::ID_W-1:0]     job_id,
    input  logic [ljfs_pkg::BURST_W-1:0]  burst,
    input  logic                          batch_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ljfs_pkg::ID_W-1:0]     job_tag,
    output logic [ljfs_pkg::BURST_W-1:0]  run_length,
    output logic [ljfs_pkg::TIME_W-1:0]   wait_time,
    output logic [ljfs_pkg::TIME_W-1:0]   turnaround,
    output logic [ljfs_pkg::TIME_W-1:0]   avg_wait,
    output logic [ljfs_pkg::TIME_W-1:0]   avg_turnaround,
    output logic                          final_result,
    output logic                          overflow
);
    import ljfs_pkg::*;

    ljfs_cmd_t    cmd;
    ljfs_status_t status;

    ljfs_ctrl #(
        .MAX_JOBS (MAX_JOBS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .batch_end (batch_end),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ljfs_datapath #(
        .MAX_JOBS (MAX_JOBS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_id         (job_id),
        .burst          (burst),
        .cmd            (cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .job_tag        (job_tag),
        .run_length     (run_length),
        .wait_time      (wait_time),
        .turnaround     (turnaround),
        .avg_wait       (avg_wait),
        .avg_turnaround (avg_turnaround),
        .final_result   (final_result),
        .overflow       (overflow)
    );

endmodule

/* dv/longest_job_first_schedule_tb.sv */
// Self-checking testbench for longest_job_first_schedule: job batches in, run slots out,
// with a scoreboard that sorts each batch and works out waiting and turnaround times.
// Depends on ljfs_pkg and the longest_job_first_schedule RTL.
`timescale 1ns / 100ps

module longest_job_first_schedule_tb;

    import ljfs_pkg::*;

    localparam int MAX_JOBS      = MAX_JOBS_DEF;
    localparam int RANDOM_ITEMS  = 200;
    localparam int QUIET_ITEMS   = 50;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [ID_W-1:0]    tag;
        logic [BURST_W-1:0] len;
        logic [TIME_W-1:0]  wait_tm;
        logic [TIME_W-1:0]  turn;
        logic [TIME_W-1:0]  avg_w;
        logic [TIME_W-1:0]  avg_t;
        logic               last;
        logic               ovf;
    } run_slot_t;

    class sched_scoreboard;
        run_slot_t          slots_due[$];
        logic [ID_W-1:0]    batch_tags[$];
        logic [BURST_W-1:0] batch_bursts[$];
        bit                 batch_dropped;
        int                 cap;
        int                 mismatches;
        int                 jobs_seen;
        int                 batches_closed;
        int                 overflow_batches;
        int                 slots_checked;

        function new(int max_jobs);
            cap = max_jobs;
        endfunction

        function logic [TIME_W-1:0] sat_time(longint v);
            return (v > SAT15) ? TIME_W'(SAT15) : TIME_W'(v);
        endfunction

        // Store the job; on batch close, stable-sort longest first and build the run slots.
        function void note_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] b, logic close);
            logic [BURST_W-1:0] kb;
            logic [ID_W-1:0]    kt;
            int                 k;
            int                 n;
            longint             clock_now;
            longint             total_wait;
            longint             total_turn;
            run_slot_t          slot;
            jobs_seen++;
            if (batch_tags.size() < cap)
            begin
                batch_tags.push_back(id);
                batch_bursts.push_back(b);
            end
            else
                batch_dropped = 1'b1;
            if (!close)
                return;
            n = batch_tags.size();
            for (int i = 1; i < n; i++)
            begin
                kb = batch_bursts[i];
                kt = batch_tags[i];
                k  = i;
                while (k > 0 && batch_bursts[k-1] < kb)
                begin
                    batch_bursts[k] = batch_bursts[k-1];
                    batch_tags[k]   = batch_tags[k-1];
                    k--;
                end
                batch_bursts[k] = kb;
                batch_tags[k]   = kt;
            end
            clock_now  = 0;
            total_wait = 0;
            total_turn = 0;
            for (int i = 0; i < n; i++)
            begin
                slot.tag     = batch_tags[i];
                slot.len     = batch_bursts[i];
                slot.wait_tm = sat_time(clock_now);
                total_wait  += clock_now;
                clock_now   += batch_bursts[i];
                total_turn  += clock_now;
                slot.turn    = sat_time(clock_now);
                slot.last    = (i == n - 1);
                slot.ovf     = batch_dropped;
                slot.avg_w   = slot.last ? sat_time(total_wait / n) : '0;
                slot.avg_t   = slot.last ? sat_time(total_turn / n) : '0;
                slots_due.push_back(slot);
            end
            batches_closed++;
            if (batch_dropped)
                overflow_batches++;
            batch_tags.delete();
            batch_bursts.delete();
            batch_dropped = 1'b0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("[%0t] slot %0d %s: got %0d expected %0d",
                     $realtime, slots_checked, what, got, want);
        endtask

        task check_slot(logic [ID_W-1:0] tag, logic [BURST_W-1:0] len,
                        logic [TIME_W-1:0] wt, logic [TIME_W-1:0] ta,
                        logic [TIME_W-1:0] aw, logic [TIME_W-1:0] at,
                        logic last, logic ovf);
            run_slot_t want;
            if (slots_due.size() == 0)
            begin
                report_mismatch("unexpected transaction, tag", tag, 0);
                return;
            end
            want = slots_due.pop_front();
            if (tag !== want.tag)      report_mismatch("job_tag", tag, want.tag);
            if (len !== want.len)      report_mismatch("run_length", len, want.len);
            if (wt !== want.wait_tm)   report_mismatch("wait_time", wt, want.wait_tm);
            if (ta !== want.turn)      report_mismatch("turnaround", ta, want.turn);
            if (aw !== want.avg_w)     report_mismatch("avg_wait", aw, want.avg_w);
            if (at !== want.avg_t)     report_mismatch("avg_turnaround", at, want.avg_t);
            if (last !== want.last)    report_mismatch("final_result", last, want.last);
            if (ovf !== want.ovf)      report_mismatch("overflow", ovf, want.ovf);
            slots_checked++;
        endtask
    endclass

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [ID_W-1:0]    job_id     = '0;
    logic [BURST_W-1:0] burst      = '0;
    logic               batch_end  = 1'b0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [ID_W-1:0]    job_tag;
    logic [BURST_W-1:0] run_length;
    logic [TIME_W-1:0]  wait_time;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  avg_wait;
    logic [TIME_W-1:0]  avg_turnaround;
    logic               final_result;
    logic               overflow;

    bit                 idle_on = 1'b1;
    sched_scoreboard    sb = new(MAX_JOBS);

    longest_job_first_schedule #(.MAX_JOBS(MAX_JOBS)) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .job_id         (job_id),
        .burst          (burst),
        .batch_end      (batch_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .job_tag        (job_tag),
        .run_length     (run_length),
        .wait_time      (wait_time),
        .turnaround     (turnaround),
        .avg_wait       (avg_wait),
        .avg_turnaround (avg_turnaround),
        .final_result   (final_result),
        .overflow       (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_slot(job_tag, run_length, wait_time, turnaround,
                          avg_wait, avg_turnaround, final_result, overflow);
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_job(logic [ID_W-1:0] id, logic [BURST_W-1:0] b, logic close);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        job_id    <= id;
        burst     <= b;
        batch_end <= close;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_job(id, b, close);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.slots_due.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int               size;
        int               pick;
        int               random_sent;
        bit               tie_mode;
        logic [BURST_W-1:0] b;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // directed: single-job batches at the field extremes
        send_job(8'd0, 10'd0, 1'b1);
        send_job(8'd255, 10'd1023, 1'b1);
        // equal bursts must keep load order
        send_job(8'd10, 10'd5, 1'b0);
        send_job(8'd11, 10'd9, 1'b0);
        send_job(8'd12, 10'd5, 1'b0);
        send_job(8'd13, 10'd0, 1'b0);
        send_job(8'd14, 10'd9, 1'b0);
        send_job(8'd15, 10'd5, 1'b1);
        send_job(8'd20, 10'd0, 1'b0);
        send_job(8'd21, 10'd0, 1'b0);
        send_job(8'd22, 10'd0, 1'b1);
        // unsorted bursts on input, longest first on output
        send_job(8'd1, 10'd1, 1'b0);
        send_job(8'd2, 10'd2, 1'b0);
        send_job(8'd3, 10'd1023, 1'b0);
        send_job(8'd4, 10'd512, 1'b1);
        send_job(8'hAA, 10'h2AA, 1'b0);
        send_job(8'h55, 10'h155, 1'b1);
        wait_for_drain();

        // full batch of longest jobs, then an overflowing batch whose closing job is dropped
        for (int j = 0; j < MAX_JOBS; j++)
            send_job(8'(j), 10'd1023, j == MAX_JOBS - 1);
        for (int j = 0; j < MAX_JOBS + 2; j++)
            send_job(8'(255 - j), 10'($urandom_range(0, 1023)), j == MAX_JOBS + 1);
        wait_for_drain();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                size = $urandom_range(1, 6);
            else if (pick < 8)
                size = $urandom_range(7, 20);
            else if (pick == 8)
                size = MAX_JOBS;
            else
                size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
            tie_mode = ($urandom_range(0, 3) == 0);
            idle_on  = (random_sent < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            for (int j = 0; j < size; j++)
            begin
                case ($urandom_range(0, 3))
                    0:       b = tie_mode ? 10'd0 : 10'($urandom_range(0, 1023));
                    1:       b = tie_mode ? 10'd1023 : 10'($urandom_range(0, 1023));
                    2:       b = tie_mode ? 10'd512 : 10'($urandom_range(0, 1023));
                    default: b = tie_mode ? 10'd1 : 10'($urandom_range(0, 1023));
                endcase
                send_job(8'($urandom_range(0, 255)), b, j == size - 1);
                random_sent++;
            end
            if ($urandom_range(0, 5) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d jobs in %0d batches, %0d of them over capacity; %0d run slots checked",
                 sb.jobs_seen, sb.batches_closed, sb.overflow_batches, sb.slots_checked);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
